>>> rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants, widths, register indexes and the sequencer state type of
// the cardinal spline tessellator.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Control point coordinate width and the largest segment subdivision.
  localparam int COORD_BITS = 12;
  localparam int MAX_GRAIN  = 30;

  // Configuration port.
  localparam int TENSION_W  = 10;
  localparam int GRAIN_W    = 5;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TENSION         = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_BETWEEN = 1'b1;

  localparam logic [TENSION_W-1:0] TENSION_RESET = 10'd128;

  // Result sample width and its saturation bounds.
  localparam int OUT_W   = 15;
  localparam int OUT_MAX = 16383;
  localparam int OUT_MIN = -16384;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

  // Datapath widths.
  localparam int ALPHA_W = 16;                 // Q16 segment parameter
  localparam int QUO_W   = 17;                 // 65536 / divisor
  localparam int MULB_W  = 17;                 // signed second operand
  localparam int DIFF_W  = COORD_BITS + 3;     // point differences
  localparam int ACC_W   = COORD_BITS + 16;    // Q8 coefficients and Horner sums
  localparam int PROD_W  = ACC_W + MULB_W;
  localparam int DCNT_W  = 5;                  // divider bit counter
  localparam int DIV_STEPS = QUO_W - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_COEF,
    S_HORN,
    S_EMIT,
    S_PUSH,
    S_ENDPT
  } cst_state_t;

endpackage

>>> rtl/cardinal_spline_tessellator_core.sv
// ----------------------------------------------------------------------------
// cardinal_spline_tessellator_core
// Tessellates a cardinal spline through a stream of 2-D control points with
// one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transaction content
//  -------  ---------  ---------------------------------------------------------
//  in_*     slave      one control point: x, y, tlast marks the final point
//  out_*    master     one curve sample: x, y, tlast = last of this point,
//                      tuser = endpoint closing the curve
//  cfg_*    write      tension (index 0), samples_between (index 1)
//
//  Each point passes a bit-serial divider for 65536 / (grain + 1), then
//  emits its segments and, for a last point, the endpoint. Each sample
//  takes three Horner steps and a rounding step for each axis, then the
//  output load. Reset is synchronous and active low; it restores the
//  register defaults and starts a new curve. A stalled output holds the
//  sequencer in place.
//
module cardinal_spline_tessellator_core (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cst_pkg::IN_TDATA_W-1:0]     in_tdata,   // point_x, point_y
  input  logic                               in_tlast,

  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cst_pkg::OUT_TDATA_W-1:0]    out_tdata,  // curve_x, curve_y
  output logic                               out_tlast,
  output logic                               out_tuser,  // curve_end

  input  logic                               cfg_wr_en,
  input  logic [cst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  cst_pkg::cst_state_t state_r, state_nxt;

  logic [cst_pkg::TENSION_W-1:0]  tension_r;
  logic [cst_pkg::GRAIN_W-1:0]    grain_cfg_r;

  // Sliding window of the extended point sequence, oldest first.
  logic [cst_pkg::COORD_BITS-1:0] win_x_r [3];
  logic [cst_pkg::COORD_BITS-1:0] win_y_r [3];
  logic [1:0]                     seen_r;

  // The point being processed.
  logic [cst_pkg::COORD_BITS-1:0] px_r, py_r;
  logic                           last_r;

  // Bit-serial divider producing 65536 / div and its remainder.
  logic [cst_pkg::DCNT_W-1:0]     div_cnt_r;
  logic [cst_pkg::GRAIN_W-1:0]    drem_r;
  logic [cst_pkg::QUO_W-1:0]      quo_r;

  // Sample parameter tracking: alpha = round(j * 65536 / div).
  logic [cst_pkg::ALPHA_W-1:0]    alpha_r;
  logic [cst_pkg::GRAIN_W-1:0]    arem_r;
  logic [cst_pkg::GRAIN_W-1:0]    j_r;

  logic                           phase_r;  // 0: segment before the push
  logic                           axis_r;   // 0: x, 1: y
  logic [1:0]                     step_r;

  logic signed [cst_pkg::ACC_W-1:0] coef0_r [2];
  logic signed [cst_pkg::ACC_W-1:0] coef1_r [2];
  logic signed [cst_pkg::ACC_W-1:0] coef2_r [2];
  logic signed [cst_pkg::ACC_W-1:0] t_r;
  logic [cst_pkg::OUT_W-1:0]        vx_r, vy_r;

  // Output register.
  logic                           out_valid_r;
  logic [cst_pkg::OUT_W-1:0]      out_x_r, out_y_r;
  logic                           out_last_r, out_end_r;

  // --------------------------------------------------------------------------
  // Combinational datapath
  // --------------------------------------------------------------------------
  logic [cst_pkg::GRAIN_W-1:0]    grain, div;
  logic [cst_pkg::COORD_BITS-1:0] q0, q1, q2, q3;
  logic signed [cst_pkg::DIFF_W-1:0] q0s, q1s, q2s, q3s;
  logic signed [cst_pkg::DIFF_W-1:0] d0, d1, d2, e;
  logic signed [cst_pkg::DIFF_W-1:0] coef_d;
  logic signed [cst_pkg::ACC_W-1:0]  e_w, coef_add, coef_nxt;
  logic signed [cst_pkg::ACC_W-1:0]  mul_a, horn_add, t_nxt, t_rnd;
  logic signed [cst_pkg::MULB_W-1:0] mul_b;
  logic signed [cst_pkg::PROD_W-1:0] prod, prod_rnd, prod_sh;
  logic [cst_pkg::OUT_W-1:0]         sat_v;
  logic [cst_pkg::GRAIN_W:0]         div_shift, asum;
  logic                              div_ge, wrap;
  logic [cst_pkg::ALPHA_W-1:0]       alpha_nxt;
  logic [1:0]                        seen_after;
  logic                              out_free, in_accept, out_load;

  assign grain = (grain_cfg_r > cst_pkg::GRAIN_W'(cst_pkg::MAX_GRAIN))
                 ? cst_pkg::GRAIN_W'(cst_pkg::MAX_GRAIN) : grain_cfg_r;
  assign div   = grain + cst_pkg::GRAIN_W'(1);

  // Window taps and the incoming point of the selected axis.
  assign q0 = axis_r ? win_y_r[0] : win_x_r[0];
  assign q1 = axis_r ? win_y_r[1] : win_x_r[1];
  assign q2 = axis_r ? win_y_r[2] : win_x_r[2];
  assign q3 = axis_r ? py_r : px_r;

  assign q0s = $signed(cst_pkg::DIFF_W'(q0));
  assign q1s = $signed(cst_pkg::DIFF_W'(q1));
  assign q2s = $signed(cst_pkg::DIFF_W'(q2));
  assign q3s = $signed(cst_pkg::DIFF_W'(q3));

  // The cardinal basis factored so that each coefficient needs a single
  // product with the tension:
  //   c0 = s*(q3 - q0 + q2 - q1) + 512*(q1 - q2)
  //   c1 = s*(2*q0 + q1 - 2*q2 - q3) - 768*(q1 - q2)
  //   c2 = s*(q2 - q0)
  assign d0 = q3s - q0s + q2s - q1s;
  assign d1 = (q0s <<< 1) + q1s - (q2s <<< 1) - q3s;
  assign d2 = q2s - q0s;
  assign e  = q1s - q2s;
  assign e_w = cst_pkg::ACC_W'(e);

  always_comb begin
    case (step_r)
      2'd0: begin
        coef_d   = d0;
        coef_add = e_w <<< 9;
      end
      2'd1: begin
        coef_d   = d1;
        coef_add = -(e_w <<< 9) - (e_w <<< 8);
      end
      default: begin
        coef_d   = d2;
        coef_add = '0;
      end
    endcase
  end

  // Shared multiplier: tension times a difference while building the
  // coefficients, alpha times the running sum during Horner evaluation.
  always_comb begin
    if (state_r == cst_pkg::S_COEF) begin
      mul_a = cst_pkg::ACC_W'(coef_d);
      mul_b = $signed(cst_pkg::MULB_W'(tension_r));
    end else begin
      mul_a = (step_r == 2'd0) ? coef0_r[axis_r] : t_r;
      mul_b = $signed(cst_pkg::MULB_W'(alpha_r));
    end
  end

  assign prod     = cst_pkg::PROD_W'(mul_a) * cst_pkg::PROD_W'(mul_b);
  assign prod_rnd = prod + cst_pkg::PROD_W'(32768);
  assign prod_sh  = prod_rnd >>> 16;

  assign coef_nxt = $signed(prod[cst_pkg::ACC_W-1:0]) + coef_add;

  always_comb begin
    case (step_r)
      2'd0:    horn_add = coef1_r[axis_r];
      2'd1:    horn_add = coef2_r[axis_r];
      default: horn_add = $signed(cst_pkg::ACC_W'({q1, 8'h00}));
    endcase
  end

  assign t_nxt = horn_add + $signed(prod_sh[cst_pkg::ACC_W-1:0]);

  // Q8 to integer, half up, then clamp to the output range.
  assign t_rnd = (t_r + cst_pkg::ACC_W'(128)) >>> 8;

  always_comb begin
    if (t_rnd > cst_pkg::ACC_W'(cst_pkg::OUT_MAX)) begin
      sat_v = cst_pkg::OUT_W'(cst_pkg::OUT_MAX);
    end else if (t_rnd < cst_pkg::ACC_W'(cst_pkg::OUT_MIN)) begin
      sat_v = cst_pkg::OUT_W'(cst_pkg::OUT_MIN);
    end else begin
      sat_v = t_rnd[cst_pkg::OUT_W-1:0];
    end
  end

  // Restoring divider step: the dividend 65536 has its only set bit first.
  assign div_shift = {drem_r, (div_cnt_r == cst_pkg::DCNT_W'(cst_pkg::DIV_STEPS))};
  assign div_ge    = div_shift >= {1'b0, div};

  // Next alpha: add the quotient, carry one when the remainder wraps.
  assign asum      = {1'b0, arem_r} + {1'b0, drem_r};
  assign wrap      = asum >= {1'b0, div};
  assign alpha_nxt = alpha_r + quo_r[cst_pkg::ALPHA_W-1:0]
                     + cst_pkg::ALPHA_W'(wrap);

  assign seen_after = (seen_r == 2'd0) ? 2'd2 :
                      (seen_r == 2'd3) ? 2'd3 : seen_r + 2'd1;

  assign out_free = !out_valid_r || out_tready;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cst_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = cst_pkg::S_DIV;
        end
      end
      cst_pkg::S_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = (seen_r == 2'd3) ? cst_pkg::S_COEF : cst_pkg::S_PUSH;
        end
      end
      cst_pkg::S_COEF: begin
        if (axis_r && step_r == 2'd2) begin
          state_nxt = cst_pkg::S_HORN;
        end
      end
      cst_pkg::S_HORN: begin
        if (axis_r && step_r == 2'd3) begin
          state_nxt = cst_pkg::S_EMIT;
        end
      end
      cst_pkg::S_EMIT: begin
        if (out_free) begin
          if (j_r == grain) begin
            state_nxt = phase_r ? cst_pkg::S_ENDPT : cst_pkg::S_PUSH;
          end else begin
            state_nxt = cst_pkg::S_HORN;
          end
        end
      end
      cst_pkg::S_PUSH: begin
        if (!last_r) begin
          state_nxt = cst_pkg::S_IDLE;
        end else if (seen_after == 2'd3) begin
          state_nxt = cst_pkg::S_COEF;
        end else begin
          state_nxt = cst_pkg::S_ENDPT;
        end
      end
      cst_pkg::S_ENDPT: begin
        if (out_free) begin
          state_nxt = cst_pkg::S_IDLE;
        end
      end
      default: state_nxt = cst_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      cst_pkg::S_IDLE:  in_tready = rst_n;
      cst_pkg::S_EMIT:  out_load  = out_free;
      cst_pkg::S_ENDPT: out_load  = out_free;
      default: begin
        in_tready = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  assign in_accept = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cst_pkg::S_IDLE;
      tension_r   <= cst_pkg::TENSION_RESET;
      grain_cfg_r <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      axis_r      <= 1'b0;
      step_r      <= '0;
      div_cnt_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          cst_pkg::REG_TENSION:         tension_r   <= cfg_data[cst_pkg::TENSION_W-1:0];
          cst_pkg::REG_SAMPLES_BETWEEN: grain_cfg_r <= cfg_data[cst_pkg::GRAIN_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        cst_pkg::S_IDLE: begin
          if (in_accept) begin
            phase_r   <= 1'b0;
            axis_r    <= 1'b0;
            step_r    <= '0;
            div_cnt_r <= cst_pkg::DCNT_W'(cst_pkg::DIV_STEPS);
          end
        end
        cst_pkg::S_DIV: begin
          if (div_cnt_r != '0) begin
            div_cnt_r <= div_cnt_r - cst_pkg::DCNT_W'(1);
          end
        end
        cst_pkg::S_COEF: begin
          if (step_r == 2'd2) begin
            step_r <= '0;
            axis_r <= !axis_r;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        cst_pkg::S_HORN: begin
          if (step_r == 2'd3) begin
            step_r <= '0;
            axis_r <= !axis_r;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        cst_pkg::S_PUSH: begin
          // The first point of a curve enters the window twice.
          if (seen_r == 2'd0) begin
            win_x_r[0] <= win_x_r[2];
            win_y_r[0] <= win_y_r[2];
            win_x_r[1] <= px_r;
            win_y_r[1] <= py_r;
          end else begin
            win_x_r[0] <= win_x_r[1];
            win_y_r[0] <= win_y_r[1];
            win_x_r[1] <= win_x_r[2];
            win_y_r[1] <= win_y_r[2];
          end
          win_x_r[2] <= px_r;
          win_y_r[2] <= py_r;
          seen_r     <= seen_after;
          phase_r    <= 1'b1;
        end
        cst_pkg::S_ENDPT: begin
          // The endpoint closes the curve; the next point starts a new one.
          if (out_free) begin
            seen_r <= '0;
            for (int i = 0; i < 3; i++) begin
              win_x_r[i] <= '0;
              win_y_r[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      cst_pkg::S_IDLE: begin
        if (in_accept) begin
          px_r   <= in_tdata[cst_pkg::COORD_BITS-1:0];
          py_r   <= in_tdata[2*cst_pkg::COORD_BITS-1:cst_pkg::COORD_BITS];
          last_r <= in_tlast;
          drem_r <= '0;
          quo_r  <= '0;
        end
      end
      cst_pkg::S_DIV: begin
        if (div_ge) begin
          drem_r <= cst_pkg::GRAIN_W'(div_shift - {1'b0, div});
        end else begin
          drem_r <= div_shift[cst_pkg::GRAIN_W-1:0];
        end
        quo_r <= {quo_r[cst_pkg::QUO_W-2:0], div_ge};
      end
      cst_pkg::S_COEF: begin
        j_r     <= '0;
        alpha_r <= '0;
        arem_r  <= div >> 1;
        case (step_r)
          2'd0:    coef0_r[axis_r] <= coef_nxt;
          2'd1:    coef1_r[axis_r] <= coef_nxt;
          default: coef2_r[axis_r] <= coef_nxt;
        endcase
      end
      cst_pkg::S_HORN: begin
        if (step_r != 2'd3) begin
          t_r <= t_nxt;
        end else if (axis_r) begin
          vy_r <= sat_v;
        end else begin
          vx_r <= sat_v;
        end
      end
      cst_pkg::S_EMIT: begin
        if (out_free && j_r != grain) begin
          j_r     <= j_r + cst_pkg::GRAIN_W'(1);
          alpha_r <= alpha_nxt;
          arem_r  <= wrap ? cst_pkg::GRAIN_W'(asum - {1'b0, div})
                          : asum[cst_pkg::GRAIN_W-1:0];
        end
      end
      default: ;
    endcase

    if (out_load) begin
      if (state_r == cst_pkg::S_ENDPT) begin
        out_x_r    <= cst_pkg::OUT_W'(px_r);
        out_y_r    <= cst_pkg::OUT_W'(py_r);
        out_last_r <= 1'b1;
        out_end_r  <= 1'b1;
      end else begin
        out_x_r    <= vx_r;
        out_y_r    <= vy_r;
        // Without a closing segment, the last sample of the leading segment
        // ends this point's transactions.
        out_last_r <= !phase_r && !last_r && (j_r == grain);
        out_end_r  <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cst_pkg::OUT_TDATA_W - 2*cst_pkg::OUT_W){1'b0}}, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

endmodule
